>>> hdl/okss_pkg.sv
// shared types and constants for the ordered key set block
package okss_pkg;

  // key width; the leaf, middle and top levels of the set are laid out for 16 bits
  localparam int KeyBits  = 16;
  localparam int WordBits = 64;
  localparam int PosBits  = 6;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_DELETE = 2'd1,
    MODE_TEST   = 2'd2,
    MODE_SUCC   = 2'd3
  } mode_t;

  typedef struct packed {
    logic       found;
    logic [5:0] pos;
  } scan_t;

  // lowest set bit of w at or above position lo, as one priority search
  function automatic scan_t lowest_from(input logic [63:0] w, input logic [6:0] lo);
    scan_t r;
    r.found = 1'b0;
    r.pos   = '0;
    for (int i = 63; i >= 0; i--) begin
      if (w[i] && (7'(i) >= lo)) begin
        r.found = 1'b1;
        r.pos   = 6'(i);
      end
    end
    return r;
  endfunction

  function automatic logic [5:0] highest_bit(input logic [63:0] w);
    logic [5:0] p;
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (w[i]) p = 6'(i);
    end
    return p;
  endfunction

endpackage

>>> hdl/ordered_key_set_successor.sv
// ordered key set with insert, delete, membership test and successor query
// Each item runs through a small sequencer that reads the three bitmap levels
// (leaf word memory, middle summary memory, top summary register) one after
// another, using one shared bit scan unit. Keys are 16 bits. The block takes
// one item at a time: s_tready is high only while idle, so a new item is not
// accepted until the result of the last one is loaded. An insert of a new key,
// or a delete that empties its leaf word, also updates the middle and top
// summaries; a successor not found in the key's own leaf word searches the
// middle summary and then the top summary. Every item ends with a walk down
// both sides of the tree for the minimum and maximum, skipped when the set is
// empty. A result still waiting in the output register holds the next item back
// only when that item is ready to load. After reset a clearing pass sweeps all
// 1024 words of the leaf memory, one word a cycle, before the first item is
// accepted.
module ordered_key_set_successor (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // mode[1:0], key[17:2], zero fill
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata    // hit, next_valid, next_key, set_empty, min_key, max_key
);

  localparam int KeyBits = okss_pkg::KeyBits;
  localparam int LeafAw  = KeyBits - 6;
  localparam int MidAw   = KeyBits - 12;
  localparam int LeafN   = 1 << LeafAw;
  localparam int MidN    = 1 << MidAw;

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_RD    = 12'b000000000100,
    S_OP    = 12'b000000001000,
    S_WR    = 12'b000000010000,
    S_MIDRD = 12'b000000100000,
    S_MIDWR = 12'b000001000000,
    S_SUCM  = 12'b000010000000,
    S_SUCL  = 12'b000100000000,
    S_BLO   = 12'b001000000000,
    S_BHI   = 12'b010000000000,
    S_OUT   = 12'b100000000000
  } state_t;

  state_t state;

  logic [63:0] leaf_mem [LeafN];
  logic [63:0] mid_mem  [MidN];
  logic [MidN-1:0] top_summary;

  logic [LeafAw-1:0] clr_addr;
  logic [1:0]  mode;
  logic [KeyBits-1:0] x;
  logic [63:0] leaf_word, mid_word;
  logic [LeafAw-1:0] leaf_raddr;
  logic [MidAw-1:0]  mid_raddr;
  logic        hit, nv, empty;
  logic [15:0] nk, lo_key, hi_key;
  logic [2:0]  sub;       // walk step inside succ / bounds
  logic [LeafAw-1:0] wl;  // leaf index under walk

  // shared scan unit
  logic [63:0] sc_word;
  logic [6:0]  sc_start;
  okss_pkg::scan_t sc_low;
  logic [5:0]  sc_high;

  okss_scan u_scan (.word(sc_word), .start(sc_start), .low(sc_low), .high(sc_high));

  wire [5:0]        kb  = x[5:0];
  wire [LeafAw-1:0] lw  = x[KeyBits-1:6];
  wire [MidAw-1:0]  mw  = x[KeyBits-1:12];
  wire [63:0] top64 = 64'(top_summary);

  // read ports registered
  always_ff @(posedge clk) begin
    leaf_word <= leaf_mem[leaf_raddr];
    mid_word  <= mid_mem[mid_raddr];
  end

  logic [63:0] leaf_new, mid_new;
  logic leaf_we, mid_we;
  logic [LeafAw-1:0] leaf_waddr;
  logic [MidAw-1:0]  mid_waddr;
  always_ff @(posedge clk) begin
    if (leaf_we) leaf_mem[leaf_waddr] <= leaf_new;
    if (mid_we)  mid_mem[mid_waddr] <= mid_new;
  end

  // mid memory is cleared during the first cycles of the leaf sweep
  logic mid_clr;
  assign mid_clr = (state == S_CLEAR) && (clr_addr < LeafAw'(MidN));

  always_comb begin
    sc_word  = leaf_word;
    sc_start = 7'd0;
    unique case (state)
      S_OP:   sc_start = {1'b0, kb} + 7'd1;
      S_SUCM: begin
        sc_word  = (sub == 3'd0) ? mid_word : top64;
        sc_start = (sub == 3'd0) ? {1'b0, lw[5:0]} + 7'd1 : 7'(mw) + 7'd1;
      end
      S_SUCL: sc_word = (sub == 3'd1) ? mid_word : leaf_word;
      S_BLO, S_BHI: begin
        unique case (sub)
          3'd0: sc_word = top64;
          3'd2: sc_word = mid_word;
          default: sc_word = leaf_word;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    leaf_we = 1'b0; leaf_waddr = lw; leaf_new = leaf_word;
    mid_we = 1'b0; mid_waddr = mw; mid_new = mid_word;
    if (state == S_CLEAR) begin
      leaf_we = 1'b1; leaf_waddr = clr_addr; leaf_new = '0;
      mid_we = mid_clr; mid_waddr = clr_addr[MidAw-1:0]; mid_new = '0;
    end else if (state == S_WR && mode == okss_pkg::MODE_INSERT && !hit) begin
      leaf_we = 1'b1; leaf_new = leaf_word | (64'd1 << kb);
    end else if (state == S_WR && mode == okss_pkg::MODE_DELETE && hit) begin
      leaf_we = 1'b1; leaf_new = leaf_word & ~(64'd1 << kb);
    end else if (state == S_MIDWR) begin
      mid_we = 1'b1;
      if (mode == okss_pkg::MODE_INSERT) mid_new = mid_word | (64'd1 << lw[5:0]);
      else mid_new = mid_word & ~(64'd1 << lw[5:0]);
    end
  end

  always_comb begin
    leaf_raddr = lw;
    mid_raddr  = mw;
    if (state == S_IDLE) begin
      leaf_raddr = s_tdata[8 +: LeafAw];
      mid_raddr  = s_tdata[14 +: MidAw];
    end else if (state == S_SUCM || state == S_BLO || state == S_BHI || state == S_SUCL) begin
      leaf_raddr = wl;
      mid_raddr  = wl[LeafAw-1:6];
    end
  end

  logic [15:0] full_key;
  assign full_key = 16'({wl, sc_low.pos});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_addr <= '0;
      top_summary <= '0;
      m_tvalid <= 1'b0;
      empty <= 1'b1;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (clr_addr == LeafAw'(LeafN - 1)) state <= S_IDLE;
          clr_addr <= clr_addr + 1'b1;
        end
        S_IDLE: if (s_tvalid) begin
          mode <= s_tdata[1:0];
          x    <= s_tdata[2 +: KeyBits];
          nv <= 1'b0; nk <= '0; sub <= '0;
          state <= S_RD;
        end
        S_RD: state <= S_OP;
        S_OP: begin
          hit <= leaf_word[kb];
          priority if (mode == okss_pkg::MODE_SUCC) begin
            if (sc_low.found) begin
              nv <= 1'b1; nk <= 16'({lw, sc_low.pos});
              state <= S_BLO;
            end else begin
              wl <= lw; state <= S_SUCM;
            end
          end else if (mode == okss_pkg::MODE_TEST) state <= S_BLO;
          else state <= S_WR;
        end
        S_WR: begin
          if ((mode == okss_pkg::MODE_INSERT && !hit) ||
              (mode == okss_pkg::MODE_DELETE && hit && leaf_new == '0))
            state <= S_MIDRD;
          else state <= S_BLO;
        end
        S_MIDRD: state <= S_MIDWR;
        S_MIDWR: begin
          if (mode == okss_pkg::MODE_INSERT) top_summary[mw] <= 1'b1;
          else if (mid_new == '0) top_summary[mw] <= 1'b0;
          state <= S_BLO; sub <= '0;
        end
        S_SUCM: begin
          // sub 0: mid word of key, sub 1: top summary
          if (sub == 3'd0 && sc_low.found) begin
            wl <= {mw, sc_low.pos}; sub <= 3'd2; state <= S_SUCL;
          end else if (sub == 3'd0) sub <= 3'd1;
          else if (sc_low.found) begin
            wl <= LeafAw'({sc_low.pos, 6'd0}); sub <= 3'd0; state <= S_SUCL;
          end else begin
            sub <= '0; state <= S_BLO;
          end
        end
        S_SUCL: begin
          // sub 0 wait mid, 1 scan mid, 2 wait leaf, 3 scan leaf
          unique case (sub)
            3'd0: sub <= 3'd1;
            3'd1: begin
              wl <= {wl[LeafAw-1:6], sc_low.pos}; sub <= 3'd2;
            end
            3'd2: sub <= 3'd3;
            default: begin
              nv <= 1'b1; nk <= full_key; sub <= '0; state <= S_BLO;
            end
          endcase
        end
        S_BLO, S_BHI: begin
          // sub 0 top, 1 wait, 2 mid, 3 wait, 4 leaf
          unique case (sub)
            3'd0: begin
              if (top_summary == '0) begin
                empty <= 1'b1; lo_key <= '0; hi_key <= '0; state <= S_OUT;
              end else begin
                empty <= 1'b0;
                wl <= LeafAw'({(state == S_BLO) ? sc_low.pos : sc_high, 6'd0});
                sub <= 3'd1;
              end
            end
            3'd1: sub <= 3'd2;
            3'd2: begin
              wl <= {wl[LeafAw-1:6], (state == S_BLO) ? sc_low.pos : sc_high};
              sub <= 3'd3;
            end
            3'd3: sub <= 3'd4;
            default: begin
              if (state == S_BLO) begin
                lo_key <= full_key; sub <= '0; state <= S_BHI;
              end else begin
                hi_key <= 16'({wl, sc_high}); state <= S_OUT;
              end
            end
          endcase
        end
        S_OUT: if (!m_tvalid || m_tready) begin
          m_tvalid <= 1'b1;
          m_tdata <= {5'd0, hi_key, lo_key, empty, nk, nv, hit};
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
    end
  end

  assign s_tready = (state == S_IDLE);

  ap_succ_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1] |-> m_tdata[17:2] != 16'd0 || m_tdata[2])
    else $error("successor flagged with zero key");
  ap_empty_bounds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[18] |-> m_tdata[34:19] == 16'd0 && m_tdata[50:35] == 16'd0)
    else $error("empty set with nonzero bounds");
  ap_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[34:19] <= m_tdata[50:35])
    else $error("minimum above maximum");

endmodule

>>> hdl/okss_scan.sv
// shared bit scan unit: lowest set bit from a start position, and highest set bit
module okss_scan (
  input  logic [63:0]         word,
  input  logic [6:0]          start,
  output okss_pkg::scan_t     low,
  output logic [5:0]          high
);

  assign low  = okss_pkg::lowest_from(word, start);
  assign high = okss_pkg::highest_bit(word);

endmodule

>>> bench/ordered_key_set_successor_tb.sv
// testbench for the ordered key set: directed probes and random set traffic checked against a bit-set model
`timescale 1ns / 1ps

class key_set_board;
  bit members [0:65535];
  typedef struct packed {
    logic        hit;
    logic        next_valid;
    logic [15:0] next_key;
    logic        set_empty;
    logic [15:0] min_key;
    logic [15:0] max_key;
  } answer_t;
  answer_t pending [$];
  int population;
  int errors;

  function void note_request(input logic [1:0] mode, input logic [15:0] key);
    answer_t a;
    int k;
    a = '0;
    a.hit = members[key];
    if (mode == okss_pkg::MODE_INSERT && !members[key]) begin
      members[key] = 1'b1;
      population++;
    end else if (mode == okss_pkg::MODE_DELETE && members[key]) begin
      members[key] = 1'b0;
      population--;
    end else if (mode == okss_pkg::MODE_SUCC) begin
      for (k = int'(key) + 1; k < 65536; k++) begin
        if (members[k]) begin
          a.next_valid = 1'b1;
          a.next_key = k[15:0];
          break;
        end
      end
    end
    a.set_empty = (population == 0);
    if (population != 0) begin
      for (k = 0; k < 65536; k++) if (members[k]) begin a.min_key = k[15:0]; break; end
      for (k = 65535; k >= 0; k--) if (members[k]) begin a.max_key = k[15:0]; break; end
    end
    pending = {pending, a};
  endfunction

  function void check_answer(input logic [55:0] got);
    answer_t want;
    answer_t seen;
    seen = {got[0], got[1], got[17:2], got[18], got[34:19], got[50:35]};
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    want = pending.pop_front();
    if (seen !== want) begin
      errors++;
      if (errors <= 10)
        $display({"mismatch: expected hit %b nv %b nk %h empty %b min %h max %h,",
                  " got hit %b nv %b nk %h empty %b min %h max %h"},
                 want.hit, want.next_valid, want.next_key, want.set_empty, want.min_key,
                 want.max_key, seen.hit, seen.next_valid, seen.next_key, seen.set_empty,
                 seen.min_key, seen.max_key);
    end
  endfunction
endclass

module ordered_key_set_successor_tb;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [55:0] m_tdata;

  key_set_board board;
  bit quiet;
  logic [15:0] hot_keys [0:15];

  ordered_key_set_successor uut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Some tests failed");
    $finish;
  end

  task automatic send_request(input okss_pkg::mode_t mode, input logic [15:0] key);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 11);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {6'd0, key, mode};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.note_request(mode, key);
  endtask

  // result side: random stalls, check on every accepted item
  initial begin
    int stall;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        stall = $urandom_range(1, 11);
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      if (m_tvalid && m_tready) board.check_answer(m_tdata);
    end
  end

  initial begin
    int i;
    logic [15:0] k;
    okss_pkg::mode_t op;
    board = new();
    quiet = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // empty set probes, extremes, duplicate insert, absent delete, top of universe
    send_request(okss_pkg::MODE_SUCC, 16'h0000);
    send_request(okss_pkg::MODE_DELETE, 16'h1234);
    send_request(okss_pkg::MODE_INSERT, 16'h0000);
    send_request(okss_pkg::MODE_INSERT, 16'hFFFF);
    send_request(okss_pkg::MODE_INSERT, 16'hFFFF);
    send_request(okss_pkg::MODE_TEST, 16'hFFFF);
    send_request(okss_pkg::MODE_SUCC, 16'hFFFF);
    send_request(okss_pkg::MODE_SUCC, 16'h0000);
    send_request(okss_pkg::MODE_INSERT, 16'h5555);
    send_request(okss_pkg::MODE_INSERT, 16'hAAAA);
    send_request(okss_pkg::MODE_SUCC, 16'h5555);
    send_request(okss_pkg::MODE_SUCC, 16'h0FFF);
    send_request(okss_pkg::MODE_DELETE, 16'h0000);
    send_request(okss_pkg::MODE_DELETE, 16'h0000);
    send_request(okss_pkg::MODE_DELETE, 16'hFFFF);
    send_request(okss_pkg::MODE_SUCC, 16'hAAAA);
    send_request(okss_pkg::MODE_DELETE, 16'h5555);
    send_request(okss_pkg::MODE_DELETE, 16'hAAAA);
    send_request(okss_pkg::MODE_TEST, 16'hAAAA);

    // sender holds off until every result is back
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);

    for (i = 0; i < 16; i++) hot_keys[i] = 16'($urandom);
    for (i = 0; i < 1400; i++) begin
      if (i == 1200) quiet = 1'b1;
      op = okss_pkg::mode_t'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0: k = 16'($urandom);
        1: k = hot_keys[$urandom_range(0, 15)];
        2: k = hot_keys[$urandom_range(0, 15)] ^ 16'(1 << $urandom_range(0, 15));
        default: k = 16'($urandom_range(0, 511)) | (16'($urandom_range(0, 1)) << 15);
      endcase
      // early on lean toward inserts so the set grows deep
      if (i < 300 && $urandom_range(0, 1) == 0) op = okss_pkg::MODE_INSERT;
      send_request(op, k);
    end
    s_tvalid <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/okss_pkg.sv
hdl/okss_scan.sv
hdl/ordered_key_set_successor.sv
bench/ordered_key_set_successor_tb.sv
